### sv/sli_pkg.sv
package sli_pkg;

    localparam int VALUE_W          = 32;
    localparam int DEFAULT_CAPACITY = 16;
    localparam int COUNT_OUT_W      = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LIST   = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY    = 2'd3;

    // what every cell does in one cycle
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;
    localparam logic [1:0] CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

### sv/sorted_list_insert_delete.sv
// Insert and delete: the status word is registered in the execute state, together
// with the cell chain update; a new item is taken only once the block is idle again.
// List: one setup step in the execute state, then one full rotation of the chain
// past the head cell; the first word follows the setup step, then one word per cycle
// for the stored values while the output is not stalled. A stalled output holds the chain.
// Reset (rst_n low, asynchronous) empties the store and drops any pending word.
module sorted_list_insert_delete
    import sli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic signed [VALUE_W-1:0]     value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic signed [VALUE_W-1:0]     value_out,
    output logic                          last,
    output logic [COUNT_OUT_W-1:0]        count_out
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CAPACITY - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_LIST = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [1:0]                kind_reg, kind_next;
    logic signed [VALUE_W-1:0] word_reg, word_next;

    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                status_reg, status_next;
    logic signed [VALUE_W-1:0] value_out_reg, value_out_next;
    logic                      last_reg, last_next;

    cell_ctl_t                 ctl;
    logic signed [VALUE_W-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]       cell_lt;
    logic [CAPACITY-1:0]       cell_eq;
    logic                      found;
    logic                      out_free;
    logic                      emit;
    logic [CNT_W-1:0]          step_ext;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [VALUE_W-1:0] left_v;
            logic                      left_l;
            logic signed [VALUE_W-1:0] right_v;
            if (g == 0)
            begin : g_head
                assign left_v = ctl.value;
                assign left_l = 1'b1;
            end
            else
            begin : g_body
                assign left_v = cell_val[g-1];
                assign left_l = cell_lt[g-1];
            end
            // the tail wraps to the head so a full rotation restores the order
            assign right_v = cell_val[(g + 1) % CAPACITY];

            sli_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .count     (count_reg),
                .left_val  (left_v),
                .left_lt   (left_l),
                .right_val (right_v),
                .val       (cell_val[g]),
                .lt        (cell_lt[g]),
                .eq        (cell_eq[g])
            );
        end
    endgenerate

    assign found    = |cell_eq;
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign step_ext = CNT_W'(step_reg);
    assign emit     = step_ext < count_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        word_next      = word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        value_out_next = value_out_reg;
        last_next      = last_reg;
        ctl.op         = CELL_HOLD;
        ctl.value      = word_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = kind;
                    word_next = value;
                    // unused kind: drop with no word out
                    if (kind inside {KIND_INSERT, KIND_DELETE, KIND_LIST})
                        state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (kind_reg == KIND_LIST)
                begin
                    if (count_reg == '0)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STATUS_EMPTY;
                            value_out_next = '0;
                            last_next      = 1'b1;
                            state_next     = ST_IDLE;
                        end
                    end
                    else
                    begin
                        step_next  = '0;
                        state_next = ST_LIST;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                    status_next    = STATUS_OK;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (count_reg == CNT_FULL)
                            status_next = STATUS_FULL;
                        else
                        begin
                            ctl.op     = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                            status_next = STATUS_EMPTY;
                        else if (!found)
                            status_next = STATUS_NOTFOUND;
                        else
                        begin
                            ctl.op     = CELL_DELETE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            ST_LIST:
            begin
                // the head cell holds entry step; advance only when its word can go out
                if (!emit || out_free)
                begin
                    ctl.op = CELL_ROTATE;
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = STATUS_OK;
                        value_out_next = cell_val[0];
                        last_next      = (step_ext + 1'b1) == count_reg;
                    end
                    if (step_reg == STEP_LAST)
                        state_next = ST_IDLE;
                    else
                        step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        word_reg      <= word_next;
        status_reg    <= status_next;
        value_out_reg <= value_out_next;
        last_reg      <= last_next;
    end

    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign value_out  = value_out_reg;
    assign last       = last_reg;
    assign count_out  = count_wide[COUNT_OUT_W-1:0];

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("stored count above capacity");

    a_count_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_EXEC))
        else $error("count changed outside an insert or delete");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EXEC || $past(state_reg) == ST_LIST))
        else $error("word raised outside execute or list");

endmodule

### sv/sli_cell.sv
module sli_cell
    import sli_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
)
(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic [CNT_W-1:0]          count,
    input  logic signed [VALUE_W-1:0] left_val,
    input  logic                      left_lt,
    input  logic signed [VALUE_W-1:0] right_val,
    output logic signed [VALUE_W-1:0] val,
    output logic                      lt,
    output logic                      eq
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;
    logic                      occ;

    assign occ = MY_IDX < count;
    assign lt  = occ && (val_reg < ctl.value);
    assign eq  = occ && (val_reg == ctl.value);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                // cells below the slot keep, the slot takes the word, the rest shift up
                if (!lt)
                begin
                    if (left_lt)
                        val_next = ctl.value;
                    else
                        val_next = left_val;
                end
            end
            CELL_DELETE:
            begin
                if (!lt)
                    val_next = right_val;
            end
            CELL_ROTATE:
            begin
                val_next = right_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

### dv/sli_checker.sv
`timescale 1ns / 1ps

module sli_checker
    import sli_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [1:0]                kind,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [1:0]                status,
    input  logic signed [VALUE_W-1:0] value_out,
    input  logic                      last,
    input  logic [COUNT_OUT_W-1:0]    count_out,
    output int                        mismatches,
    output int                        owed_count
);

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] value_out;
        logic                      last;
        logic [COUNT_OUT_W-1:0]    count_out;
    } list_word_t;

    logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
    int                        shadow_len;
    list_word_t                owed_words [$];

    function automatic void owe_word(logic [1:0] st, logic signed [VALUE_W-1:0] v, logic lst);
        list_word_t w;
        w.status    = st;
        w.value_out = v;
        w.last      = lst;
        w.count_out = shadow_len[COUNT_OUT_W-1:0];
        owed_words.push_back(w);
    endfunction

    function automatic void apply_list_op(logic [1:0] k, logic signed [VALUE_W-1:0] v);
        int pos;
        int i;
        case (k)
            KIND_INSERT:
            begin
                if (shadow_len >= CAPACITY)
                begin
                    owe_word(STATUS_FULL, '0, 1'b1);
                end
                else
                begin
                    // equal values: the new one goes before the stored ones, at the first one not smaller
                    pos = 0;
                    while (pos < shadow_len && shadow_list[pos] < v)
                        pos++;
                    for (i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = v;
                    shadow_len++;
                    owe_word(STATUS_OK, '0, 1'b1);
                end
            end
            KIND_DELETE:
            begin
                if (shadow_len == 0)
                begin
                    owe_word(STATUS_EMPTY, '0, 1'b1);
                end
                else
                begin
                    pos = 0;
                    while (pos < shadow_len && shadow_list[pos] != v)
                        pos++;
                    if (pos >= shadow_len)
                    begin
                        owe_word(STATUS_NOTFOUND, '0, 1'b1);
                    end
                    else
                    begin
                        for (i = pos; i + 1 < shadow_len; i++)
                            shadow_list[i] = shadow_list[i+1];
                        shadow_len--;
                        owe_word(STATUS_OK, '0, 1'b1);
                    end
                end
            end
            KIND_LIST:
            begin
                if (shadow_len == 0)
                begin
                    owe_word(STATUS_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (i = 0; i < shadow_len; i++)
                        owe_word(STATUS_OK, shadow_list[i], (i + 1 == shadow_len));
                end
            end
            default:
            begin
                // unused kind: no word, no change
            end
        endcase
    endfunction

    function automatic void check_word();
        list_word_t want;
        if (owed_words.size() == 0)
        begin
            if (mismatches < 10)
                $display("%0t: unexpected word status %0d value %0d last %0d count %0d",
                         $realtime, status, value_out, last, count_out);
            mismatches++;
        end
        else
        begin
            want = owed_words.pop_front();
            if (status !== want.status || value_out !== want.value_out ||
                last !== want.last || count_out !== want.count_out)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: word mismatch, expected status %0d value %0d last %0d count %0d",
                             $realtime, want.status, want.value_out, want.last,
                             want.count_out);
                    $display("%0t: word mismatch, got status %0d value %0d last %0d count %0d",
                             $realtime, status, value_out, last, count_out);
                end
                mismatches++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_len = 0;
            owed_words.delete();
            owed_count = 0;
        end
        else
        begin
            // a word leaving now can never stem from the item taken at this edge
            if (out_valid && out_ready)
                check_word();
            if (in_valid && in_ready)
                apply_list_op(kind, value);
            owed_count = owed_words.size();
        end
    end

endmodule

### dv/tb_sorted_list_insert_delete.sv
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;
    import sli_pkg::*;

    localparam int CAPACITY    = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] value_out;
    logic                      last;
    logic [COUNT_OUT_W-1:0]    count_out;

    int mismatches;
    int owed_count;
    int cycle_count;
    bit send_burst;
    logic signed [VALUE_W-1:0] recent_vals [$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_list_insert_delete #(.CAPACITY(CAPACITY)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_out (value_out),
        .last      (last),
        .count_out (count_out)
    );

    sli_checker #(.CAPACITY(CAPACITY)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value_out  (value_out),
        .last       (last),
        .count_out  (count_out),
        .mismatches (mismatches),
        .owed_count (owed_count)
    );

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer_word(input logic [1:0] k, input logic signed [VALUE_W-1:0] v);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (k == KIND_INSERT)
        begin
            recent_vals.push_back(v);
            if (recent_vals.size() > 32)
                void'(recent_vals.pop_front());
        end
        @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed($urandom_range(0, 8)) - 4;
        else if (r < 55)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return -1;
                default: return 0;
            endcase
        end
        else
            return $signed($urandom);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_delete_value();
        int idx;
        logic signed [VALUE_W-1:0] v;
        if (recent_vals.size() > 0 && $urandom_range(0, 99) < 65)
        begin
            idx = $urandom_range(0, recent_vals.size() - 1);
            v = recent_vals[idx];
            recent_vals.delete(idx);
            return v;
        end
        return pick_value();
    endfunction

    // receiver: random stall per word, one long hold-off to back up the block
    initial
    begin
        int gap;
        int words_taken;
        bit recv_burst;
        out_ready = 1'b0;
        words_taken = 0;
        recv_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (words_taken % 30 == 0)
                recv_burst = ($urandom_range(0, 2) == 0);
            gap = recv_burst ? 0 : $urandom_range(0, 16);
            if (words_taken == 40)
                gap = HOLD_OFF_CYCLES;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            words_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int i;
        int r;
        bit filling;
        in_valid = 1'b0;
        kind     = KIND_INSERT;
        value    = '0;
        rst_n    = 1'b0;
        send_burst = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty store, then extremes and a duplicate
        offer_word(KIND_LIST, VAL_MAX);
        offer_word(KIND_DELETE, 5);
        offer_word(KIND_INSERT, 0);
        offer_word(KIND_INSERT, VAL_MAX);
        offer_word(KIND_INSERT, VAL_MIN);
        offer_word(KIND_INSERT, -1);
        offer_word(KIND_INSERT, 0);
        offer_word(KIND_LIST, 0);
        offer_word(KIND_DELETE, 7);
        offer_word(KIND_DELETE, 0);
        offer_word(KIND_DELETE, VAL_MIN);
        offer_word(KIND_UNUSED, 32'shffff_ffff);
        offer_word(KIND_LIST, 0);
        // fill to capacity, overflow, list it all
        for (i = 0; i < CAPACITY - 2; i++)
            offer_word(KIND_INSERT, 32'(i * 3 - 20));
        offer_word(KIND_INSERT, 1);
        offer_word(KIND_LIST, 0);

        recent_vals.delete();
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 25 == 0)
                send_burst = ($urandom_range(0, 2) == 0);
            // alternate fill-heavy and drain-heavy stretches to swing full and empty
            filling = ((i / 40) % 2) == 0;
            r = $urandom_range(0, 99);
            if (r < (filling ? 70 : 15))
                offer_word(KIND_INSERT, pick_value());
            else if (r < 85)
                offer_word(KIND_DELETE, pick_delete_value());
            else if (r < 97)
                offer_word(KIND_LIST, $signed($urandom));
            else
                offer_word(KIND_UNUSED, $signed($urandom));
        end
        in_valid <= 1'b0;

        while (owed_count != 0)
            @(posedge clk);
        repeat (2 * CAPACITY + 20) @(posedge clk);
        if (mismatches == 0 && owed_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
